// ----- rtl/ief_pkg.sv -----
// ============================================================================
// ief_pkg : shared types, constants and coefficient tables
// Fixed-point constants for the inverse error function pipeline, built at
// elaboration from decimal values rounded half up.
// ============================================================================
`default_nettype none

package ief_pkg;

  // result status codes
  localparam logic [1:0] ST_NORMAL  = 2'd0;
  localparam logic [1:0] ST_POS_INF = 2'd1;
  localparam logic [1:0] ST_NEG_INF = 2'd2;
  localparam logic [1:0] ST_NAN     = 2'd3;

  // rational coefficient sets
  localparam logic [1:0] SET_CENTRAL = 2'd0;
  localparam logic [1:0] SET_TAIL_LO = 2'd1;
  localparam logic [1:0] SET_TAIL_HI = 2'd2;

  localparam int NORM_STAGES  = 6;
  localparam int LOG_ITERS    = 58;
  localparam int SQRT_BITS    = 61;
  localparam int HORNER_STEPS = 7;
  localparam int DIV_INT      = 64;
  localparam int DIV_FRAC     = 61;
  localparam int TAIL_FRAC    = 59;
  localparam int HF           = 54;

  localparam logic [63:0] DEC18   = 64'd1000000000000000000;
  localparam logic [63:0] ONE_Q62 = 64'h4000_0000_0000_0000;
  localparam logic [63:0] LIM_085 = 64'd3919933115663279718;

  typedef struct packed {
    logic        valid;
    logic        neg;
    logic [1:0]  spec;
    logic        central;
    logic [63:0] ax;
    logic [63:0] s;
  } side_t;

  // round((ip + fr/1e18) * 2^g), half up
  function automatic logic [63:0] to_fix(input logic [63:0] ip, input logic [63:0] fr,
                                         input int g);
    logic [63:0] q;
    logic [63:0] rem;
    q   = '0;
    rem = fr;
    for (int i = 0; i < 63; i++) begin
      if (i < g) begin
        rem = {rem[62:0], 1'b0};
        q   = {q[62:0], 1'b0};
        if (rem >= DEC18) begin
          q[0] = 1'b1;
          rem  = rem - DEC18;
        end
      end
    end
    if ({rem[62:0], 1'b0} >= DEC18) q = q + 64'd1;
    return (ip << g) + q;
  endfunction

  localparam logic [63:0] S0_Q54   = to_fix(64'd0, 64'd722500000000000000, 54);
  localparam logic [63:0] LN2_Q63  = to_fix(64'd0, 64'd693147180559945309, 63);
  localparam logic [63:0] C16_Q58  = to_fix(64'd1, 64'd600000000000000000, 58);
  localparam logic [63:0] FIVE_Q58 = 64'd5 << 58;

  localparam logic [63:0] NUM_TAB [0:2][0:7] = '{
    '{to_fix(64'd1,     64'd197532311567091256, 54),
      to_fix(64'd47,    64'd72688112383978012,  52),
      to_fix(64'd697,   64'd62665343895982385,  50),
      to_fix(64'd4854,  64'd886889384388679465, 48),
      to_fix(64'd16235, 64'd862515167575384252, 46),
      to_fix(64'd23782, 64'd41382114385731252,  44),
      to_fix(64'd11819, 64'd493347062294404278, 42),
      to_fix(64'd887,   64'd94069625455148302,  40)},
    '{to_fix(64'd1, 64'd423437110749683577, 54),
      to_fix(64'd4, 64'd630337846156545296, 54),
      to_fix(64'd5, 64'd769497221460691406, 54),
      to_fix(64'd3, 64'd647848324763204605, 54),
      to_fix(64'd1, 64'd270458252452368383, 54),
      to_fix(64'd0, 64'd241780725177450612, 54),
      to_fix(64'd0, 64'd22723844989269185,  54),
      to_fix(64'd0, 64'd774545014278341,    54)},
    '{to_fix(64'd6, 64'd657904643501103777, 54),
      to_fix(64'd5, 64'd463784911164114370, 54),
      to_fix(64'd1, 64'd784826539917291336, 54),
      to_fix(64'd0, 64'd296560571828504891, 54),
      to_fix(64'd0, 64'd26532189526576123,  54),
      to_fix(64'd0, 64'd1242660947388078,   54),
      to_fix(64'd0, 64'd27115555687435,     54),
      to_fix(64'd0, 64'd201033439929,       54)}
  };

  localparam logic [63:0] DEN_TAB [0:2][0:7] = '{
    '{to_fix(64'd1,     64'd0,                  54),
      to_fix(64'd42,    64'd313330701600911252, 52),
      to_fix(64'd687,   64'd187007492057908300, 50),
      to_fix(64'd5394,  64'd196021424751107700, 48),
      to_fix(64'd21213, 64'd794301586595867000, 46),
      to_fix(64'd39307, 64'd895800092710610000, 44),
      to_fix(64'd28729, 64'd85735721942674000,  42),
      to_fix(64'd5226,  64'd495278852854561000, 40)},
    '{to_fix(64'd1, 64'd414213562373095049, 54),
      to_fix(64'd2, 64'd903651444541994617, 54),
      to_fix(64'd2, 64'd370766162602453237, 54),
      to_fix(64'd0, 64'd975478320017874272, 54),
      to_fix(64'd0, 64'd209450652105127491, 54),
      to_fix(64'd0, 64'd21494160384252877,  54),
      to_fix(64'd0, 64'd774414590651577,    54),
      to_fix(64'd0, 64'd1485985002,         54)},
    '{to_fix(64'd1, 64'd414213562373095049, 54),
      to_fix(64'd0, 64'd848290841659516459, 54),
      to_fix(64'd0, 64'd193648094695065911, 54),
      to_fix(64'd0, 64'd21036937682720690,  54),
      to_fix(64'd0, 64'd1112800997078860,   54),
      to_fix(64'd0, 64'd26110884050806,     54),
      to_fix(64'd0, 64'd201032120768,       54),
      to_fix(64'd0, 64'd2891,               54)}
  };

  function automatic logic [63:0] num_coef(input logic [1:0] set_sel, input logic [2:0] k);
    logic [63:0] c;
    case (set_sel)
      SET_TAIL_LO: c = NUM_TAB[SET_TAIL_LO][k];
      SET_TAIL_HI: c = NUM_TAB[SET_TAIL_HI][k];
      default:     c = NUM_TAB[SET_CENTRAL][k];
    endcase
    return c;
  endfunction

  function automatic logic [63:0] den_coef(input logic [1:0] set_sel, input logic [2:0] k);
    logic [63:0] c;
    case (set_sel)
      SET_TAIL_LO: c = DEN_TAB[SET_TAIL_LO][k];
      SET_TAIL_HI: c = DEN_TAB[SET_TAIL_HI][k];
      default:     c = DEN_TAB[SET_CENTRAL][k];
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/inverse_error_function_top.sv -----
// ============================================================================
// inverse_error_function_top : pipelined inverse error function
// Signed Q2.62 argument in, signed Q5.59 erfinv and a status code out.
// ============================================================================
// Accepts one word per clock and returns one word per clock unless the
// result side stalls; each word passes front end, log/sqrt, select,
// Horner, divider, final multiply and sign. The depth is set by the bit-serial
// stages: 58 squarings for log2, 61 square root bits and 125 quotient bits,
// all of them fully pipelined. A stall on the result side freezes the whole
// pipeline in place, so words are never dropped or repeated; in_stall rises
// only while a finished word is held at the output. There is no reset-time
// sweep: the block takes words in the first cycle after reset is released.
// Status: 0 normal, 1 plus infinity (x = +1, y saturated high), 2 minus
// infinity (x = -1, y saturated low), 3 not a number (|x| > 1, y = 0).
// ============================================================================
`default_nettype none

module inverse_error_function_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [63:0] in_x_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [63:0] out_y_value,
  output logic [1:0]         out_result_status
);

  localparam logic [63:0] Y_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] Y_MIN = 64'h8000_0000_0000_0000;

  // Advance every stage together unless the output word is held.
  logic en;
  logic out_valid_r;

  assign en       = ~(out_valid_r & out_stall);
  assign in_stall = ~en;
  assign out_valid = out_valid_r;

  // ---------------------------------------------------------------------
  // Front end: magnitude, special cases, branch choice, s = 0.7225 - x^2
  // ---------------------------------------------------------------------
  logic [63:0]    xu, ax;
  logic           neg;
  ief_pkg::side_t a_nxt;
  ief_pkg::side_t asd_r, amsd_r, bsd_r;
  ief_pkg::side_t b_nxt;
  logic [127:0]   ap;
  logic [63:0]    sq, s_nxt;

  always_comb begin
    xu  = in_x_value;
    neg = xu[63];
    ax  = neg ? (64'd0 - xu) : xu;
    a_nxt         = '0;
    a_nxt.valid   = in_valid;
    a_nxt.neg     = neg;
    a_nxt.ax      = ax;
    a_nxt.central = (ax <= ief_pkg::LIM_085);
    if (ax > ief_pkg::ONE_Q62) begin
      a_nxt.spec = ief_pkg::ST_NAN;
    end else if (ax == ief_pkg::ONE_Q62) begin
      a_nxt.spec = neg ? ief_pkg::ST_NEG_INF : ief_pkg::ST_POS_INF;
    end else begin
      a_nxt.spec = ief_pkg::ST_NORMAL;
    end
  end

  ief_mul64 u_sq (.clk(clk), .en(en), .a(asd_r.ax), .b(asd_r.ax), .p(ap));

  // x*x in Q.54, clamp s at zero
  assign sq    = {6'd0, ap[127:70]};
  assign s_nxt = (sq > ief_pkg::S0_Q54) ? '0 : (ief_pkg::S0_Q54 - sq);

  always_comb begin
    b_nxt   = amsd_r;
    b_nxt.s = s_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      asd_r.valid  <= 1'b0;
      amsd_r.valid <= 1'b0;
      bsd_r.valid  <= 1'b0;
    end else if (en) begin
      asd_r  <= a_nxt;
      amsd_r <= asd_r;
      bsd_r  <= b_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // Tail argument r (central words ride along untouched)
  // ---------------------------------------------------------------------
  ief_pkg::side_t lsd;
  logic [63:0]    lr;

  ief_log u_log (
    .clk(clk), .rst_n(rst_n), .en(en),
    .side_i(bsd_r), .side_o(lsd), .r_o(lr)
  );

  // Pick the coefficient set and the polynomial variable.
  logic [1:0]     wsel_nxt, wsel_r;
  logic [63:0]    wz_nxt, wz_r;
  ief_pkg::side_t wsd_r;

  always_comb begin
    wsel_nxt = ief_pkg::SET_CENTRAL;
    wz_nxt   = lsd.s;
    if (!lsd.central) begin
      if (lr <= ief_pkg::FIVE_Q58) begin
        wsel_nxt = ief_pkg::SET_TAIL_LO;
        wz_nxt   = (lr > ief_pkg::C16_Q58) ? ((lr - ief_pkg::C16_Q58) >> 4) : '0;
      end else begin
        wsel_nxt = ief_pkg::SET_TAIL_HI;
        wz_nxt   = (lr - ief_pkg::FIVE_Q58) >> 4;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wsd_r.valid <= 1'b0;
    end else if (en) begin
      wsd_r  <= lsd;
      wsel_r <= wsel_nxt;
      wz_r   <= wz_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // Rational: numerator, denominator, quotient
  // ---------------------------------------------------------------------
  ief_pkg::side_t hsd, dsd;
  logic [63:0]    hnum, hden, dq;

  ief_horner u_horner (
    .clk(clk), .rst_n(rst_n), .en(en),
    .side_i(wsd_r), .z_i(wz_r), .sel_i(wsel_r),
    .side_o(hsd), .num_o(hnum), .den_o(hden)
  );

  ief_div u_div (
    .clk(clk), .rst_n(rst_n), .en(en),
    .side_i(hsd), .num_i(hnum), .den_i(hden),
    .side_o(dsd), .q_o(dq)
  );

  // ---------------------------------------------------------------------
  // Final: central words scale by |x|, then apply sign or special value
  // ---------------------------------------------------------------------
  logic [127:0]   fp;
  logic [63:0]    fq_r;
  ief_pkg::side_t fsd_r;
  logic [63:0]    mag, y_nxt, y_r;
  logic [1:0]     st_r;

  ief_mul64 u_scale (.clk(clk), .en(en), .a(dsd.ax), .b(dq), .p(fp));

  always_comb begin
    mag = fsd_r.central ? fp[127:64] : fq_r;
    case (fsd_r.spec)
      ief_pkg::ST_POS_INF: y_nxt = Y_MAX;
      ief_pkg::ST_NEG_INF: y_nxt = Y_MIN;
      ief_pkg::ST_NAN:     y_nxt = '0;
      default:             y_nxt = fsd_r.neg ? (64'd0 - mag) : mag;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fsd_r.valid <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      fsd_r       <= dsd;
      fq_r        <= dq;
      out_valid_r <= fsd_r.valid;
      y_r         <= y_nxt;
      st_r        <= fsd_r.spec;
    end
  end

  assign out_y_value       = y_r;
  assign out_result_status = st_r;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_nan_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_result_status == ief_pkg::ST_NAN) |-> (out_y_value == 64'sd0))
    else $error("not-a-number word with nonzero value");

  a_pos_inf: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_result_status == ief_pkg::ST_POS_INF) |-> (out_y_value == Y_MAX))
    else $error("plus infinity not saturated");

  a_neg_inf: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_result_status == ief_pkg::ST_NEG_INF) |-> (out_y_value == Y_MIN))
    else $error("minus infinity not saturated");

  a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled without a held output word");

endmodule

`default_nettype wire

// ----- rtl/ief_mul64.sv -----
// ============================================================================
// ief_mul64 : 64x64 multiplier, partial products registered
// Four 32x32 partial products are held in one register stage; the full
// 128-bit product is summed after it.
// ============================================================================
`default_nettype none

module ief_mul64 (
  input  logic         clk,
  input  logic         en,
  input  logic [63:0]  a,
  input  logic [63:0]  b,
  output logic [127:0] p
);

  logic [63:0] ll_r, lh_r, hl_r, hh_r;

  always_ff @(posedge clk) begin
    if (en) begin
      ll_r <= a[31:0]  * b[31:0];
      lh_r <= a[31:0]  * b[63:32];
      hl_r <= a[63:32] * b[31:0];
      hh_r <= a[63:32] * b[63:32];
    end
  end

  assign p = {hh_r, 64'd0} + {32'd0, lh_r, 32'd0} + {32'd0, hl_r, 32'd0} + {64'd0, ll_r};

endmodule

`default_nettype wire

// ----- rtl/ief_log.sv -----
// ============================================================================
// ief_log : tail argument r = sqrt(ln2 - ln(1-|x|))
// Normalize 1-|x|, take log2 by repeated squaring, scale by ln2 and take
// the square root one bit per stage.
// ============================================================================
`default_nettype none

module ief_log (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  ief_pkg::side_t side_i,
  output ief_pkg::side_t side_o,
  output logic [63:0]    r_o
);

  localparam int NS = ief_pkg::NORM_STAGES;
  localparam int NI = ief_pkg::LOG_ITERS;
  localparam int NQ = ief_pkg::SQRT_BITS;
  localparam int RW = 2 * NQ + 1;

  // normalization
  logic [63:0]    nv_r  [NS];
  logic [5:0]     nsh_r [NS];
  ief_pkg::side_t nsd_r [NS];

  for (genvar n = 0; n < NS; n++) begin : g_norm
    localparam int B = 32 >> n;
    logic [63:0]    v_in;
    logic [5:0]     sh_in;
    ief_pkg::side_t sd_in;
    if (n == 0) begin : g_first
      assign v_in  = ief_pkg::ONE_Q62 - side_i.ax;
      assign sh_in = '0;
      assign sd_in = side_i;
    end else begin : g_next
      assign v_in  = nv_r[n-1];
      assign sh_in = nsh_r[n-1];
      assign sd_in = nsd_r[n-1];
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        nsd_r[n].valid <= 1'b0;
      end else if (en) begin
        nsd_r[n] <= sd_in;
        if (v_in[62 -: B] == '0) begin
          nv_r[n]  <= v_in << B;
          nsh_r[n] <= sh_in + 6'(B);
        end else begin
          nv_r[n]  <= v_in;
          nsh_r[n] <= sh_in;
        end
      end
    end
  end

  // squaring chain, one fraction bit of log2 per iteration
  ief_pkg::side_t msd_r [NI];
  ief_pkg::side_t ssd_r [NI];
  logic [5:0]     msh_r [NI];
  logic [5:0]     ssh_r [NI];
  logic [NI-1:0]  mf_r  [NI];
  logic [NI-1:0]  sf_r  [NI];
  logic [63:0]    sm_r  [NI];

  for (genvar i = 0; i < NI; i++) begin : g_sq
    logic [63:0]    m_in;
    logic [NI-1:0]  f_in;
    logic [5:0]     sh_in;
    ief_pkg::side_t sd_in;
    logic [127:0]   prod;
    logic [63:0]    sq;
    if (i == 0) begin : g_first
      assign m_in  = nv_r[NS-1];
      assign f_in  = '0;
      assign sh_in = nsh_r[NS-1];
      assign sd_in = nsd_r[NS-1];
    end else begin : g_next
      assign m_in  = sm_r[i-1];
      assign f_in  = sf_r[i-1];
      assign sh_in = ssh_r[i-1];
      assign sd_in = ssd_r[i-1];
    end
    ief_mul64 u_sq (.clk(clk), .en(en), .a(m_in), .b(m_in), .p(prod));
    assign sq = prod[125:62];
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        msd_r[i].valid <= 1'b0;
        ssd_r[i].valid <= 1'b0;
      end else if (en) begin
        msd_r[i] <= sd_in;
        mf_r[i]  <= f_in;
        msh_r[i] <= sh_in;
        ssd_r[i] <= msd_r[i];
        ssh_r[i] <= msh_r[i];
        // halve on reaching two, record the bit
        if (sq[63]) begin
          sm_r[i] <= sq >> 1;
          sf_r[i] <= {mf_r[i][NI-2:0], 1'b1};
        end else begin
          sm_r[i] <= sq;
          sf_r[i] <= {mf_r[i][NI-2:0], 1'b0};
        end
      end
    end
  end

  // L = (63-k) - f, then t = L * ln2
  logic [6:0]     e1;
  logic [63:0]    lv_nxt;
  logic [63:0]    lv_r;
  ief_pkg::side_t lsd_r;
  ief_pkg::side_t lmsd_r;
  ief_pkg::side_t tsd_r;
  logic [127:0]   lp;
  logic [63:0]    t_r;

  assign e1     = {1'b0, ssh_r[NI-1]} + 7'd1;
  assign lv_nxt = {e1[5:0], {NI{1'b0}}} - {6'd0, sf_r[NI-1]};

  ief_mul64 u_ln2 (.clk(clk), .en(en), .a(lv_r), .b(ief_pkg::LN2_Q63), .p(lp));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lsd_r.valid  <= 1'b0;
      lmsd_r.valid <= 1'b0;
      tsd_r.valid  <= 1'b0;
    end else if (en) begin
      lv_r   <= lv_nxt;
      lsd_r  <= ssd_r[NI-1];
      lmsd_r <= lsd_r;
      tsd_r  <= lmsd_r;
      t_r    <= lp[126:63];
    end
  end

  // square root, one result bit per stage
  logic [RW-1:0]  qrem_r  [NQ];
  logic [NQ-1:0]  qroot_r [NQ];
  ief_pkg::side_t qsd_r   [NQ];

  for (genvar j = 0; j < NQ; j++) begin : g_sqrt
    localparam int B = NQ - 1 - j;
    logic [RW-1:0]  rem_in;
    logic [NQ-1:0]  root_in;
    ief_pkg::side_t sd_in;
    logic [RW-1:0]  trial;
    if (j == 0) begin : g_first
      assign rem_in  = {1'b0, t_r, 58'd0};
      assign root_in = '0;
      assign sd_in   = tsd_r;
    end else begin : g_next
      assign rem_in  = qrem_r[j-1];
      assign root_in = qroot_r[j-1];
      assign sd_in   = qsd_r[j-1];
    end
    assign trial = ({{(RW-NQ){1'b0}}, root_in} << (B + 1)) + ({{(RW-1){1'b0}}, 1'b1} << (2 * B));
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        qsd_r[j].valid <= 1'b0;
      end else if (en) begin
        qsd_r[j] <= sd_in;
        if (rem_in >= trial) begin
          qrem_r[j]  <= rem_in - trial;
          qroot_r[j] <= root_in | ({{(NQ-1){1'b0}}, 1'b1} << B);
        end else begin
          qrem_r[j]  <= rem_in;
          qroot_r[j] <= root_in;
        end
      end
    end
  end

  assign side_o = qsd_r[NQ-1];
  assign r_o    = {{(64-NQ){1'b0}}, qroot_r[NQ-1]};

endmodule

`default_nettype wire

// ----- rtl/ief_horner.sv -----
// ============================================================================
// ief_horner : numerator and denominator polynomials
// Seven Horner steps, each a multiplier stage and an add stage, with the
// coefficient set picked per word.
// ============================================================================
`default_nettype none

module ief_horner (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  ief_pkg::side_t side_i,
  input  logic [63:0]    z_i,
  input  logic [1:0]     sel_i,
  output ief_pkg::side_t side_o,
  output logic [63:0]    num_o,
  output logic [63:0]    den_o
);

  localparam int NH = ief_pkg::HORNER_STEPS;

  ief_pkg::side_t msd_r  [NH];
  ief_pkg::side_t hsd_r  [NH];
  logic [63:0]    mz_r   [NH];
  logic [63:0]    hz_r   [NH];
  logic [1:0]     msel_r [NH];
  logic [1:0]     hsel_r [NH];
  logic [63:0]    an_r   [NH];
  logic [63:0]    ad_r   [NH];

  for (genvar j = 0; j < NH; j++) begin : g_step
    localparam logic [2:0] K = 3'(NH - 1 - j);
    logic [63:0]    an_in, ad_in, z_in;
    logic [1:0]     sel_in;
    ief_pkg::side_t sd_in;
    logic [127:0]   pn, pd;
    if (j == 0) begin : g_first
      assign an_in  = ief_pkg::num_coef(sel_i, 3'(NH));
      assign ad_in  = ief_pkg::den_coef(sel_i, 3'(NH));
      assign z_in   = z_i;
      assign sel_in = sel_i;
      assign sd_in  = side_i;
    end else begin : g_next
      assign an_in  = an_r[j-1];
      assign ad_in  = ad_r[j-1];
      assign z_in   = hz_r[j-1];
      assign sel_in = hsel_r[j-1];
      assign sd_in  = hsd_r[j-1];
    end
    ief_mul64 u_num (.clk(clk), .en(en), .a(an_in), .b(z_in), .p(pn));
    ief_mul64 u_den (.clk(clk), .en(en), .a(ad_in), .b(z_in), .p(pd));
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        msd_r[j].valid <= 1'b0;
        hsd_r[j].valid <= 1'b0;
      end else if (en) begin
        msd_r[j]  <= sd_in;
        mz_r[j]   <= z_in;
        msel_r[j] <= sel_in;
        hsd_r[j]  <= msd_r[j];
        hz_r[j]   <= mz_r[j];
        hsel_r[j] <= msel_r[j];
        an_r[j]   <= pn[117:54] + ief_pkg::num_coef(msel_r[j], K);
        ad_r[j]   <= pd[117:54] + ief_pkg::den_coef(msel_r[j], K);
      end
    end
  end

  assign side_o = hsd_r[NH-1];
  assign num_o  = an_r[NH-1];
  assign den_o  = ad_r[NH-1];

endmodule

`default_nettype wire

// ----- rtl/ief_div.sv -----
// ============================================================================
// ief_div : fixed-point quotient floor(num * 2^g / den)
// Restoring division, one quotient bit per stage: an exact integer part,
// then fraction bits with a 64-bit remainder.
// ============================================================================
`default_nettype none

module ief_div (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  ief_pkg::side_t side_i,
  input  logic [63:0]    num_i,
  input  logic [63:0]    den_i,
  output ief_pkg::side_t side_o,
  output logic [63:0]    q_o
);

  localparam int NT = ief_pkg::DIV_INT + ief_pkg::DIV_FRAC;

  logic [63:0]    qn_r [NT];
  logic [63:0]    rm_r [NT];
  logic [63:0]    dd_r [NT];
  ief_pkg::side_t dsd_r [NT];

  for (genvar j = 0; j < NT; j++) begin : g_bit
    logic [63:0]    qn_in, rm_in, d_in;
    ief_pkg::side_t sd_in;
    if (j == 0) begin : g_first
      assign qn_in = num_i;
      assign rm_in = '0;
      assign d_in  = den_i;
      assign sd_in = side_i;
    end else begin : g_next
      assign qn_in = qn_r[j-1];
      assign rm_in = rm_r[j-1];
      assign d_in  = dd_r[j-1];
      assign sd_in = dsd_r[j-1];
    end

    if (j < ief_pkg::DIV_INT) begin : g_int
      logic [64:0] t, diff;
      assign t    = {rm_in, qn_in[63]};
      assign diff = t - {1'b0, d_in};
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          dsd_r[j].valid <= 1'b0;
        end else if (en) begin
          dsd_r[j] <= sd_in;
          dd_r[j]  <= d_in;
          if (t >= {1'b0, d_in}) begin
            rm_r[j] <= diff[63:0];
            qn_r[j] <= {qn_in[62:0], 1'b1};
          end else begin
            rm_r[j] <= t[63:0];
            qn_r[j] <= {qn_in[62:0], 1'b0};
          end
        end
      end
    end else begin : g_frac
      logic [63:0] r2;
      logic        active;
      assign r2 = {rm_in[62:0], 1'b0};
      // tail words take fewer fraction bits: hold through the last ones
      if (j - ief_pkg::DIV_INT < ief_pkg::TAIL_FRAC) begin : g_all
        assign active = 1'b1;
      end else begin : g_central
        assign active = sd_in.central;
      end
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          dsd_r[j].valid <= 1'b0;
        end else if (en) begin
          dsd_r[j] <= sd_in;
          dd_r[j]  <= d_in;
          if (!active) begin
            rm_r[j] <= rm_in;
            qn_r[j] <= qn_in;
          end else if (r2 >= d_in) begin
            rm_r[j] <= r2 - d_in;
            qn_r[j] <= {qn_in[62:0], 1'b1};
          end else begin
            rm_r[j] <= r2;
            qn_r[j] <= {qn_in[62:0], 1'b0};
          end
        end
      end
    end
  end

  assign side_o = dsd_r[NT-1];
  assign q_o    = (dd_r[NT-1] == '0) ? '0 : qn_r[NT-1];

endmodule

`default_nettype wire

// ----- dv/ief_checker.sv -----
// ----------------------------------------------------------------------------
// ief_checker : result predictor and scoreboard for the erfinv pipeline
// Watches both channels, computes the expected erfinv word for every accepted
// argument and compares each accepted result field by field, in order.
// ----------------------------------------------------------------------------
module ief_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic signed [63:0] in_x_value,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [63:0] out_y_value,
  input  logic [1:0]         out_result_status,
  output int                 fail_count,
  output int                 pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [63:0] y;
    logic [1:0]  status;
  } erfinv_word_t;

  localparam logic [63:0] BILLION2 = 64'd1000000000000000000;

  // coefficient sets: central num/den, low tail num/den, high tail num/den
  localparam longint unsigned COEF_IP [0:5][0:7] = '{
    '{64'd1, 64'd47, 64'd697, 64'd4854, 64'd16235, 64'd23782, 64'd11819, 64'd887},
    '{64'd1, 64'd42, 64'd687, 64'd5394, 64'd21213, 64'd39307, 64'd28729, 64'd5226},
    '{64'd1, 64'd4, 64'd5, 64'd3, 64'd1, 64'd0, 64'd0, 64'd0},
    '{64'd1, 64'd2, 64'd2, 64'd0, 64'd0, 64'd0, 64'd0, 64'd0},
    '{64'd6, 64'd5, 64'd1, 64'd0, 64'd0, 64'd0, 64'd0, 64'd0},
    '{64'd1, 64'd0, 64'd0, 64'd0, 64'd0, 64'd0, 64'd0, 64'd0}};
  localparam longint unsigned COEF_FR [0:5][0:7] = '{
    '{64'd197532311567091256, 64'd72688112383978012, 64'd62665343895982385,
      64'd886889384388679465, 64'd862515167575384252, 64'd41382114385731252,
      64'd493347062294404278, 64'd94069625455148302},
    '{64'd0, 64'd313330701600911252, 64'd187007492057908300, 64'd196021424751107700,
      64'd794301586595867000, 64'd895800092710610000, 64'd85735721942674000,
      64'd495278852854561000},
    '{64'd423437110749683577, 64'd630337846156545296, 64'd769497221460691406,
      64'd647848324763204605, 64'd270458252452368383, 64'd241780725177450612,
      64'd22723844989269185, 64'd774545014278341},
    '{64'd414213562373095049, 64'd903651444541994617, 64'd370766162602453237,
      64'd975478320017874272, 64'd209450652105127491, 64'd21494160384252877,
      64'd774414590651577, 64'd1485985002},
    '{64'd657904643501103777, 64'd463784911164114370, 64'd784826539917291336,
      64'd296560571828504891, 64'd26532189526576123, 64'd1242660947388078,
      64'd27115555687435, 64'd201033439929},
    '{64'd414213562373095049, 64'd848290841659516459, 64'd193648094695065911,
      64'd21036937682720690, 64'd1112800997078860, 64'd26110884050806,
      64'd201032120768, 64'd2891}};

  erfinv_word_t expected_q[$];

  function automatic logic [63:0] prod_shift(logic [63:0] a, logic [63:0] b, int sh);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return 64'(p >> sh);
  endfunction

  function automatic logic [63:0] dec_to_fixed(logic [63:0] ip, logic [63:0] fr, int g);
    logic [63:0] q;
    logic [63:0] rem;
    q = '0;
    rem = fr;
    for (int i = 0; i < g; i++) begin
      rem = rem << 1;
      q = q << 1;
      if (rem >= BILLION2) begin
        q = q | 64'd1;
        rem = rem - BILLION2;
      end
    end
    if (rem * 2 >= BILLION2) q = q + 64'd1;
    return (ip << g) + q;
  endfunction

  function automatic logic [63:0] poly_eval(int set, logic [63:0] z, int step);
    logic [63:0] acc;
    acc = dec_to_fixed(COEF_IP[set][7], COEF_FR[set][7], 54 - 7 * step);
    for (int k = 6; k >= 0; k--)
      acc = prod_shift(acc, z, 54) + dec_to_fixed(COEF_IP[set][k], COEF_FR[set][k], 54 - k * step);
    return acc;
  endfunction

  function automatic logic [63:0] frac_div(logic [63:0] n, logic [63:0] d, int g);
    logic [127:0] wide;
    if (d == 0) return '0;
    wide = ({64'd0, n} << g) / {64'd0, d};
    return wide[63:0];
  endfunction

  function automatic logic [63:0] root_q58(logic [63:0] t);
    logic [127:0] target;
    logic [63:0]  res;
    logic [63:0]  c;
    target = {64'd0, t} << 58;
    res = '0;
    for (int b = 62; b >= 0; b--) begin
      c = res | (64'd1 << b);
      if ({64'd0, c} * {64'd0, c} <= target) res = c;
    end
    return res;
  endfunction

  function automatic logic [63:0] tail_magnitude(logic [63:0] ax);
    logic [63:0] u, m, f, lval, t, r, w, num, den, c16, five;
    int k;
    u = ief_pkg::ONE_Q62 - ax;
    c16 = dec_to_fixed(64'd1, 64'd600000000000000000, 58);
    five = 64'd5 << 58;
    k = 61;
    while (k > 0 && !u[k]) k--;
    m = u << (62 - k);
    f = '0;
    for (int i = 0; i < 58; i++) begin
      m = prod_shift(m, m, 62);
      f = f << 1;
      if (m[63]) begin
        f = f | 64'd1;
        m = m >> 1;
      end
    end
    lval = (64'(63 - k) << 58) - f;
    t = prod_shift(lval, dec_to_fixed(64'd0, 64'd693147180559945309, 63), 63);
    r = root_q58(t);
    if (r <= five) begin
      w = (r > c16) ? ((r - c16) >> 4) : 64'd0;
      num = poly_eval(2, w, 0);
      den = poly_eval(3, w, 0);
    end else begin
      w = (r - five) >> 4;
      num = poly_eval(4, w, 0);
      den = poly_eval(5, w, 0);
    end
    return frac_div(num, den, 59);
  endfunction

  function automatic erfinv_word_t predict_erfinv(logic [63:0] xv);
    erfinv_word_t e;
    logic [63:0] ax, mag, sq, c0, s, num, den;
    logic neg;
    neg = xv[63];
    ax = neg ? (64'd0 - xv) : xv;
    e.status = ief_pkg::ST_NORMAL;
    if (ax > ief_pkg::ONE_Q62) begin
      e.y = '0;
      e.status = ief_pkg::ST_NAN;
    end else if (ax == ief_pkg::ONE_Q62) begin
      e.y = neg ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
      e.status = neg ? ief_pkg::ST_NEG_INF : ief_pkg::ST_POS_INF;
    end else begin
      if (ax <= ief_pkg::LIM_085) begin
        sq = prod_shift(ax, ax, 70);
        c0 = dec_to_fixed(64'd0, 64'd722500000000000000, 54);
        s = (sq > c0) ? 64'd0 : c0 - sq;
        num = poly_eval(0, s, 2);
        den = poly_eval(1, s, 2);
        mag = prod_shift(ax, frac_div(num, den, 61), 64);
      end else begin
        mag = tail_magnitude(ax);
      end
      e.y = neg ? (64'd0 - mag) : mag;
    end
    return e;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  always @(posedge clk) begin
    erfinv_word_t e;
    if (!rst_n) begin
      fail_count = 0;
      expected_q.delete();
      pending_count <= 0;
    end else begin
      if (in_valid && !in_stall) expected_q.push_back(predict_erfinv(in_x_value));
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected word", out_y_value, 64'd0);
        end else begin
          e = expected_q.pop_front();
          if (out_y_value !== e.y) report_mismatch("y_value", out_y_value, e.y);
          if (out_result_status !== e.status)
            report_mismatch("result_status", 64'(out_result_status), 64'(e.status));
        end
      end
      pending_count <= expected_q.size();
    end
  end
endmodule

// ----- dv/inverse_error_function_top_tb.sv -----
// ----------------------------------------------------------------------------
// inverse_error_function_top_tb : stimulus and verdict for the erfinv pipeline
// Drives directed corner arguments and then a random mix of central, tail,
// deep tail, saturating and out-of-range words under random idling on both
// channels; the checker beside the block does all prediction and comparison.
// ----------------------------------------------------------------------------
module inverse_error_function_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_WORDS = 1000;
  localparam int QUIET_TAIL   = 120;   // last words run with no idling
  localparam int DRAIN_CYCLES = 400;   // margin after the scoreboard queue empties

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic signed [63:0] in_x_value = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [63:0] out_y_value;
  logic [1:0]         out_result_status;
  int                 fail_count;
  int                 pending_count;
  bit                 idle_on = 1'b1;
  int                 stall_left = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  inverse_error_function_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_x_value(in_x_value),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_y_value(out_y_value), .out_result_status(out_result_status)
  );

  ief_checker scoreboard (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_x_value(in_x_value),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_y_value(out_y_value), .out_result_status(out_result_status),
    .fail_count(fail_count), .pending_count(pending_count)
  );

  // Receiver back-pressure: stall in random bursts while idling is on.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      out_stall <= 1'b1;
      stall_left <= $urandom_range(0, 2);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Present one word and hold it until the block takes it.
  task automatic send_word(logic [63:0] x);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_x_value <= x;
    do @(posedge clk); while (in_stall);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Mostly in-range arguments spread over the three rational branches,
  // with exact saturation points and raw noise mixed in.
  function automatic logic [63:0] random_argument();
    logic [63:0] ax, u;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      ax = rand64() % (ief_pkg::LIM_085 + 64'd1);
    end else if (pick < 65) begin
      ax = ief_pkg::LIM_085 + 64'd1
           + rand64() % (ief_pkg::ONE_Q62 - ief_pkg::LIM_085 - 64'd1);
    end else if (pick < 80) begin
      u = rand64() >> $urandom_range(20, 63);
      if (u == 0) u = 64'd1;
      ax = ief_pkg::ONE_Q62 - u;
    end else if (pick < 95) begin
      return rand64();
    end else begin
      ax = ief_pkg::ONE_Q62;
    end
    return $urandom_range(0, 1) ? (64'd0 - ax) : ax;
  endfunction

  initial begin
    logic [63:0] corners[$];
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // zero, saturation points, just past them, range extremes, branch edges
    corners = '{64'd0, ief_pkg::ONE_Q62, -ief_pkg::ONE_Q62,
                ief_pkg::ONE_Q62 + 64'd1, -(ief_pkg::ONE_Q62 + 64'd1),
                64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
                ief_pkg::LIM_085, -ief_pkg::LIM_085,
                ief_pkg::LIM_085 + 64'd1, -(ief_pkg::LIM_085 + 64'd1),
                ief_pkg::ONE_Q62 - 64'd1, -(ief_pkg::ONE_Q62 - 64'd1),
                ief_pkg::ONE_Q62 - 64'd2, ief_pkg::ONE_Q62 - 64'd300000000,
                ief_pkg::ONE_Q62 - 64'd100000, 64'd1, -64'd1,
                64'h2000_0000_0000_0000, -64'h2000_0000_0000_0000};
    foreach (corners[i]) send_word(corners[i]);

    for (int n = 0; n < RANDOM_WORDS; n++) begin
      // hold the sender once until the pipeline has fully drained
      if (n == RANDOM_WORDS / 2) begin
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_count != 0);
      end
      if (n == RANDOM_WORDS - QUIET_TAIL) idle_on = 1'b0;
      send_word(random_argument());
    end
    in_valid <= 1'b0;

    while (pending_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #400000;
    $display("== FAIL ==");
    $finish;
  end
endmodule
